>>> hdl/thkr_pkg.sv
// types, codes and helpers shared by the key resolver
`default_nettype none
package thkr_pkg;

	localparam int SLOTS_DEF = 8;
	localparam logic [15:0] TERM_RESET = 16'd200;

	// request opcodes
	localparam logic [1:0] OP_PRESS   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_OTHER   = 2'd2;
	localparam logic [1:0] OP_TICK    = 2'd3;

	// child bindings
	localparam logic [1:0] C_TAP   = 2'd0;
	localparam logic [1:0] C_HOLD  = 2'd1;
	localparam logic [1:0] C_LAYER = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_IGN  = 2'd2;

	typedef enum logic [2:0] {
		M_FREE  = 3'd0,
		M_DOWN  = 3'd1,
		M_TAPP  = 3'd2,
		M_HOLD  = 3'd3,
		M_LAYER = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FIND,
		S_RESOLVE,
		S_NEWPRESS,
		S_SCAN,
		S_SECOND,
		S_END
	} state_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  position;
		logic [31:0] timestamp;
	} item_t;

	typedef struct packed {
		logic        action_valid;
		logic [1:0]  child;
		logic        pressed;
		logic [7:0]  action_position;
		logic [32:0] action_time;
		logic [1:0]  status;
		logic        last;
	} res_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  key;
		logic [32:0] deadline;
	} slot_t;

	typedef struct packed {
		logic        en;
		logic        load;
		mode_t       mode;
		logic [7:0]  key;
		logic [32:0] deadline;
	} slot_wr_t;

	function automatic res_t mk_act(input logic [1:0] child, input logic pressed,
			input logic [7:0] pos, input logic [32:0] t);
		res_t r;
		r = '0;
		r.action_valid    = 1'b1;
		r.child           = child;
		r.pressed         = pressed;
		r.action_position = pos;
		r.action_time     = t;
		r.status          = ST_OK;
		r.last            = 1'b0;
		return r;
	endfunction

	function automatic res_t mk_trail(input logic [1:0] status);
		res_t r;
		r = '0;
		r.status = status;
		r.last   = 1'b1;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> hdl/tap_hold_doubletap_key_resolver.sv
// top level: tap / hold / tap-then-hold key resolver sequencer
//
// channel   direction  handshake               payload
// request   in         start, busy             item (op, position, timestamp)
// result    out        res_valid, one cycle    res (action fields, status, last)
// config    in         term_we                 term_wdata (tapping term, ms)
//
// press and release: the accept, a lookup pass over all SLOTS slots, a resolve and a closing step, plus a
// step for an action that follows another of the same slot and one for taking a new slot;
// other key and tick: the accept, a scan over all slots, a step per flushed tap, then the closing step.
// the slot scan goes one slot a cycle through the shared deadline comparator, held for each flushed tap.
// reset clears every slot to free and the tapping term to 200.
// results leave through an output register and cannot be held off.
`default_nettype none
module tap_hold_doubletap_key_resolver #(
	parameter int SLOTS = thkr_pkg::SLOTS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire thkr_pkg::item_t item,
	output logic             res_valid,
	output thkr_pkg::res_t   res,
	input  wire logic        term_we,
	input  wire logic [15:0] term_wdata
);
	import thkr_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	state_t           st_q, st_d, ret_q, ret_d;
	logic [1:0]       op_q, op_d;
	logic [7:0]       pos_q, pos_d;
	logic [31:0]      ts_q, ts_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             hit_q, hit_d, free_q, free_d;
	logic [IDX_W-1:0] hit_idx_q, hit_idx_d, free_idx_q, free_idx_d, tgt_q, tgt_d;
	logic [1:0]       status_q, status_d;
	res_t             sec_q, sec_d, pend_q, pend_d, res_q, res_d;
	logic             pend_v_q, pend_v_d, res_v_q, res_v_d;
	logic [15:0]      term_q;

	logic [IDX_W-1:0] cnt_idx, rd_idx, wr_idx;
	logic             cnt_last, ge, pending, fire;
	logic [32:0]      ts33, dl_new, t_sel;
	slot_t            slot;
	slot_wr_t         wr;
	logic             em_v;
	res_t             em;

	thkr_slots #(
		.SLOTS(SLOTS),
		.IDX_W(IDX_W)
	) u_slots (
		.clk   (clk),
		.arst_n(arst_n),
		.rd_idx(rd_idx),
		.rd    (slot),
		.wr_idx(wr_idx),
		.wr    (wr)
	);

	assign cnt_idx  = cnt_q[IDX_W-1:0];
	assign cnt_last = (cnt_q == CNT_W'(SLOTS - 1));
	assign rd_idx   = (st_q == S_RESOLVE) ? hit_idx_q : cnt_idx;
	assign ts33     = {1'b0, ts_q};
	assign dl_new   = ts33 + 33'(term_q);
	// the one shared deadline comparator
	assign ge       = (ts33 >= slot.deadline);
	assign pending  = (slot.mode == M_DOWN) || (slot.mode == M_TAPP);
	assign fire     = (op_q == OP_OTHER) ? (pending && (slot.key != pos_q))
	                                     : (pending && ge);
	assign t_sel    = ge ? slot.deadline : ts33;

	always_comb begin
		st_d       = st_q;
		ret_d      = ret_q;
		op_d       = op_q;
		pos_d      = pos_q;
		ts_d       = ts_q;
		cnt_d      = cnt_q;
		hit_d      = hit_q;
		hit_idx_d  = hit_idx_q;
		free_d     = free_q;
		free_idx_d = free_idx_q;
		tgt_d      = tgt_q;
		status_d   = status_q;
		sec_d      = sec_q;
		pend_d     = pend_q;
		pend_v_d   = pend_v_q;
		res_d      = res_q;
		res_v_d    = 1'b0;
		wr         = '0;
		wr.mode    = M_FREE;
		wr_idx     = cnt_idx;
		em_v       = 1'b0;
		em         = '0;
		case (st_q)
			S_IDLE: begin
				if (start) begin
					op_d     = item.op;
					pos_d    = item.position;
					ts_d     = item.timestamp;
					cnt_d    = '0;
					hit_d    = 1'b0;
					free_d   = 1'b0;
					status_d = ST_OK;
					pend_v_d = 1'b0;
					st_d     = (item.op == OP_PRESS || item.op == OP_RELEASE) ? S_FIND : S_SCAN;
				end
			end
			S_FIND: begin
				// lowest matching slot and lowest free slot in one pass
				if (slot.mode != M_FREE && slot.key == pos_q && !hit_q) begin
					hit_d     = 1'b1;
					hit_idx_d = cnt_idx;
				end
				if (slot.mode == M_FREE && !free_q) begin
					free_d     = 1'b1;
					free_idx_d = cnt_idx;
				end
				cnt_d = cnt_q + 1'b1;
				if (cnt_last) begin
					st_d = S_RESOLVE;
				end
			end
			S_RESOLVE: begin
				wr_idx = hit_idx_q;
				st_d   = S_END;
				if (op_q == OP_PRESS) begin
					if (!hit_q) begin
						if (free_q) begin
							tgt_d = free_idx_q;
							st_d  = S_NEWPRESS;
						end else begin
							status_d = ST_FULL;
						end
					end else if (slot.mode != M_TAPP) begin
						status_d = ST_IGN;
					end else if (ge) begin
						// late second press: flush the tap, then a fresh first press
						em_v    = 1'b1;
						em      = mk_act(C_TAP, 1'b1, slot.key, slot.deadline);
						sec_d   = mk_act(C_TAP, 1'b0, slot.key, slot.deadline);
						ret_d   = S_NEWPRESS;
						st_d    = S_SECOND;
						wr.en   = 1'b1;
						wr.mode = M_FREE;
						tgt_d   = (free_q && free_idx_q < hit_idx_q) ? free_idx_q : hit_idx_q;
					end else begin
						wr.en   = 1'b1;
						wr.mode = M_LAYER;
						em_v    = 1'b1;
						em      = mk_act(C_LAYER, 1'b1, slot.key, ts33);
					end
				end else begin
					if (!hit_q) begin
						status_d = ST_IGN;
					end else begin
						case (slot.mode)
							M_DOWN: begin
								wr.en = 1'b1;
								if (!ge) begin
									wr.mode = M_TAPP;
								end else begin
									wr.mode = M_FREE;
									em_v    = 1'b1;
									em      = mk_act(C_HOLD, 1'b1, slot.key, slot.deadline);
									sec_d   = mk_act(C_HOLD, 1'b0, slot.key, ts33);
									ret_d   = S_END;
									st_d    = S_SECOND;
								end
							end
							M_HOLD: begin
								wr.en   = 1'b1;
								wr.mode = M_FREE;
								em_v    = 1'b1;
								em      = mk_act(C_HOLD, 1'b0, slot.key, ts33);
							end
							M_LAYER: begin
								wr.en   = 1'b1;
								wr.mode = M_FREE;
								em_v    = 1'b1;
								em      = mk_act(C_LAYER, 1'b0, slot.key, ts33);
							end
							default: begin
								status_d = ST_IGN;
							end
						endcase
					end
				end
			end
			S_NEWPRESS: begin
				wr_idx      = tgt_q;
				wr.en       = 1'b1;
				wr.load     = 1'b1;
				wr.key      = pos_q;
				wr.deadline = dl_new;
				st_d        = S_END;
				// zero term: the deadline is already here
				if (term_q == '0) begin
					wr.mode = M_HOLD;
					em_v    = 1'b1;
					em      = mk_act(C_HOLD, 1'b1, pos_q, dl_new);
				end else begin
					wr.mode = M_DOWN;
				end
			end
			S_SCAN: begin
				cnt_d = cnt_q + 1'b1;
				st_d  = cnt_last ? S_END : S_SCAN;
				if (fire) begin
					em_v  = 1'b1;
					wr.en = 1'b1;
					if (slot.mode == M_DOWN) begin
						wr.mode = M_HOLD;
						em      = mk_act(C_HOLD, 1'b1, slot.key, t_sel);
					end else begin
						wr.mode = M_FREE;
						em      = mk_act(C_TAP, 1'b1, slot.key, t_sel);
						sec_d   = mk_act(C_TAP, 1'b0, slot.key, t_sel);
						ret_d   = cnt_last ? S_END : S_SCAN;
						st_d    = S_SECOND;
					end
				end
			end
			S_SECOND: begin
				em_v = 1'b1;
				em   = sec_q;
				st_d = ret_q;
			end
			S_END: begin
				res_v_d = 1'b1;
				if (pend_v_q) begin
					res_d      = pend_q;
					res_d.last = (status_q == ST_OK);
					pend_v_d   = 1'b0;
					if (status_q == ST_OK) begin
						st_d = S_IDLE;
					end
				end else begin
					res_d = mk_trail(status_q);
					st_d  = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
		// one result held back so the final one can be marked last
		if (em_v) begin
			if (pend_v_q) begin
				res_v_d = 1'b1;
				res_d   = pend_q;
			end
			pend_d   = em;
			pend_v_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			pend_v_q <= 1'b0;
			res_v_q  <= 1'b0;
			term_q   <= TERM_RESET;
		end else begin
			st_q     <= st_d;
			pend_v_q <= pend_v_d;
			res_v_q  <= res_v_d;
			if (term_we) begin
				term_q <= term_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		ret_q      <= ret_d;
		op_q       <= op_d;
		pos_q      <= pos_d;
		ts_q       <= ts_d;
		cnt_q      <= cnt_d;
		hit_q      <= hit_d;
		hit_idx_q  <= hit_idx_d;
		free_q     <= free_d;
		free_idx_q <= free_idx_d;
		tgt_q      <= tgt_d;
		status_q   <= status_d;
		sec_q      <= sec_d;
		pend_q     <= pend_d;
		res_q      <= res_d;
	end

	assign busy      = (st_q != S_IDLE);
	assign res_valid = res_v_q;
	assign res       = res_q;

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |-> !busy)
		else $error("last result while request still in progress");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_action_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.action_valid |-> res.status == ST_OK)
		else $error("action result carries a nonzero status");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> res_valid && res.last)
		else $error("request finished without a last result");

endmodule
`default_nettype wire

>>> hdl/thkr_slots.sv
// slot table: mode, key position and deadline of each slot
`default_nettype none
module thkr_slots #(
	parameter int SLOTS = thkr_pkg::SLOTS_DEF,
	parameter int IDX_W = 3
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [IDX_W-1:0] rd_idx,
	output thkr_pkg::slot_t       rd,
	input  wire logic [IDX_W-1:0] wr_idx,
	input  wire thkr_pkg::slot_wr_t wr
);
	import thkr_pkg::*;

	mode_t       mode_q [SLOTS];
	logic [7:0]  key_q  [SLOTS];
	logic [32:0] dl_q   [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				mode_q[i] <= M_FREE;
			end
		end else if (wr.en) begin
			mode_q[wr_idx] <= wr.mode;
		end
	end

	// key and deadline only change when a slot is taken
	always_ff @(posedge clk) begin
		if (wr.en && wr.load) begin
			key_q[wr_idx] <= wr.key;
			dl_q[wr_idx]  <= wr.deadline;
		end
	end

	always_comb begin
		rd.mode     = mode_q[rd_idx];
		rd.key      = key_q[rd_idx];
		rd.deadline = dl_q[rd_idx];
	end

endmodule
`default_nettype wire

>>> tb/tb_tap_hold_doubletap_key_resolver.sv
// self-checking testbench for the tap / hold / tap-then-hold key resolver
`timescale 1ns / 1ps
module tb_tap_hold_doubletap_key_resolver;
	import thkr_pkg::*;

	localparam int NSLOT        = SLOTS_DEF;
	localparam int SETTLE       = 2 * NSLOT + 24;
	localparam int LIMIT_CYCLES = 500000;

	// tracks slot state, predicts the actions of every request and checks them in order
	class key_resolver_scoreboard;
		logic [15:0] term;
		mode_t       slot_mode[NSLOT];
		logic [7:0]  slot_pos[NSLOT];
		logic [32:0] slot_due[NSLOT];
		res_t        expected_q[$];
		res_t        item_res[$];
		int          errors;

		function new();
			term = TERM_RESET;
			for (int i = 0; i < NSLOT; i++) begin
				slot_mode[i] = M_FREE;
				slot_pos[i]  = '0;
				slot_due[i]  = '0;
			end
			errors = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void emit(int s, logic [1:0] ch, logic pr, logic [32:0] t);
			res_t r;
			r                 = '0;
			r.action_valid    = 1'b1;
			r.child           = ch;
			r.pressed         = pr;
			r.action_position = slot_pos[s];
			r.action_time     = t;
			r.status          = ST_OK;
			item_res.push_back(r);
		endfunction

		function void go_hold(int s, logic [32:0] t);
			slot_mode[s] = M_HOLD;
			emit(s, C_HOLD, 1'b1, t);
		endfunction

		function void flush_tap(int s, logic [32:0] t);
			emit(s, C_TAP, 1'b1, t);
			emit(s, C_TAP, 1'b0, t);
			slot_mode[s] = M_FREE;
		endfunction

		function void settle_due(int s);
			if (slot_mode[s] == M_DOWN)
				go_hold(s, slot_due[s]);
			else if (slot_mode[s] == M_TAPP)
				flush_tap(s, slot_due[s]);
		endfunction

		function int lookup(logic [7:0] pos);
			for (int i = 0; i < NSLOT; i++)
				if (slot_mode[i] != M_FREE && slot_pos[i] == pos)
					return i;
			return -1;
		endfunction

		function logic [1:0] claim_slot(logic [7:0] pos, logic [32:0] now_t);
			for (int i = 0; i < NSLOT; i++) begin
				if (slot_mode[i] == M_FREE) begin
					slot_mode[i] = M_DOWN;
					slot_pos[i]  = pos;
					slot_due[i]  = now_t + {17'd0, term};
					// zero term: the press itself is already at the deadline
					if (slot_due[i] <= now_t)
						settle_due(i);
					return ST_OK;
				end
			end
			return ST_FULL;
		endfunction

		function void note_request(item_t rq);
			logic [32:0] now_t;
			logic [1:0]  st;
			int          s;
			res_t        tr;
			now_t = {1'b0, rq.timestamp};
			st    = ST_OK;
			item_res.delete();
			case (rq.op)
				OP_PRESS: begin
					s = lookup(rq.position);
					if (s < 0) begin
						st = claim_slot(rq.position, now_t);
					end else if (slot_mode[s] != M_TAPP) begin
						st = ST_IGN;
					end else if (now_t >= slot_due[s]) begin
						flush_tap(s, slot_due[s]);
						st = claim_slot(rq.position, now_t);
					end else begin
						slot_mode[s] = M_LAYER;
						emit(s, C_LAYER, 1'b1, now_t);
					end
				end
				OP_RELEASE: begin
					s = lookup(rq.position);
					if (s < 0) begin
						st = ST_IGN;
					end else if (slot_mode[s] == M_DOWN) begin
						if (now_t < slot_due[s]) begin
							slot_mode[s] = M_TAPP;
						end else begin
							go_hold(s, slot_due[s]);
							emit(s, C_HOLD, 1'b0, now_t);
							slot_mode[s] = M_FREE;
						end
					end else if (slot_mode[s] == M_HOLD) begin
						emit(s, C_HOLD, 1'b0, now_t);
						slot_mode[s] = M_FREE;
					end else if (slot_mode[s] == M_LAYER) begin
						emit(s, C_LAYER, 1'b0, now_t);
						slot_mode[s] = M_FREE;
					end else begin
						st = ST_IGN;
					end
				end
				OP_OTHER: begin
					for (int i = 0; i < NSLOT; i++) begin
						if (slot_mode[i] == M_FREE || slot_pos[i] == rq.position)
							continue;
						if (slot_mode[i] != M_DOWN && slot_mode[i] != M_TAPP)
							continue;
						if (now_t >= slot_due[i])
							settle_due(i);
						else if (slot_mode[i] == M_DOWN)
							go_hold(i, now_t);
						else
							flush_tap(i, now_t);
					end
				end
				default: begin
					for (int i = 0; i < NSLOT; i++)
						if ((slot_mode[i] == M_DOWN || slot_mode[i] == M_TAPP) &&
								now_t >= slot_due[i])
							settle_due(i);
				end
			endcase
			if (item_res.size() == 0 || st != ST_OK) begin
				tr        = '0;
				tr.status = st;
				item_res.push_back(tr);
			end
			tr      = item_res.pop_back();
			tr.last = 1'b1;
			item_res.push_back(tr);
			foreach (item_res[i])
				expected_q.push_back(item_res[i]);
		endfunction

		function void cmp(string name, logic [32:0] e, logic [32:0] a);
			if (e !== a) begin
				$display("%0t: %s expected %0h, actual %0h", $time, name, e, a);
				errors++;
			end
		endfunction

		function void check_result(res_t got);
			res_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: result with nothing expected, actual %p", $time, got);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			cmp("action_valid", 33'(e.action_valid), 33'(got.action_valid));
			cmp("child", 33'(e.child), 33'(got.child));
			cmp("pressed", 33'(e.pressed), 33'(got.pressed));
			cmp("action_position", 33'(e.action_position), 33'(got.action_position));
			cmp("action_time", e.action_time, got.action_time);
			cmp("status", 33'(e.status), 33'(got.status));
			cmp("last", 33'(e.last), 33'(got.last));
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	item_t       item;
	logic        res_valid;
	res_t        res;
	logic        term_we;
	logic [15:0] term_wdata;

	key_resolver_scoreboard sb;
	int          n_accepted;
	int          cycles;
	logic [31:0] now_ms;
	bit          idling;
	logic [7:0]  pool[$];

	tap_hold_doubletap_key_resolver #(
		.SLOTS(NSLOT)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.res_valid (res_valid),
		.res       (res),
		.term_we   (term_we),
		.term_wdata(term_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// results are checked before a request at the same edge is noted
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end else if (arst_n) begin
			if (res_valid)
				sb.check_result(res);
			if (start && !busy) begin
				sb.note_request(item);
				n_accepted++;
			end
		end
	end

	task automatic send(input logic [1:0] op, input logic [7:0] pos);
		int goal;
		if (idling && $urandom_range(0, 2) == 0) begin
			start = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		item.op        = op;
		item.position  = pos;
		item.timestamp = now_ms;
		start          = 1'b1;
		goal           = n_accepted + 1;
		while (n_accepted < goal)
			@(negedge clk);
	endtask

	task automatic step_time(input logic [31:0] d);
		if (d > 32'hFFFF_FFFF - now_ms)
			now_ms = 32'hFFFF_FFFF;
		else
			now_ms = now_ms + d;
	endtask

	// steps are mostly scaled to the tapping term so deadlines fall on both sides
	task automatic random_delay();
		logic [31:0] t32;
		int unsigned k;
		t32 = {16'd0, sb.term};
		k   = $urandom_range(0, 49);
		if (k == 0)
			step_time($urandom_range(0, 1 << 24));
		else case (k % 4)
			0: ;
			1: step_time($urandom_range(0, t32 / 2));
			2: begin
				if (t32 == 0)
					step_time($urandom_range(0, 1));
				else
					step_time(t32 - 1 + $urandom_range(0, 2));
			end
			default: step_time($urandom_range(0, 2 * t32 + 20));
		endcase
	endtask

	task automatic drain();
		start = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_term(input logic [15:0] v);
		term_we    = 1'b1;
		term_wdata = v;
		@(negedge clk);
		sb.term = v;
		term_we = 1'b0;
	endtask

	// release every pool key, then a tick past every deadline leaves all slots free
	task automatic release_pool();
		foreach (pool[i]) begin
			step_time($urandom_range(0, 3));
			send(OP_RELEASE, pool[i]);
		end
		step_time({16'd0, sb.term} + 1);
		send(OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic run_phase(input logic [15:0] t, input int n, input bit last_phase);
		int unsigned r;
		int          sz;
		logic [7:0]  k;
		drain();
		write_term(t);
		pool.delete();
		sz = $urandom_range(2, 10);
		for (int i = 0; i < sz; i++) begin
			r = $urandom_range(0, 9);
			pool.push_back(r == 0 ? 8'd0 : r == 1 ? 8'd255 : 8'($urandom_range(0, 255)));
		end
		for (int i = 0; i < n; i++) begin
			if (i % 8 == 0)
				idling = !last_phase && $urandom_range(0, 3) != 0;
			random_delay();
			k = pool[$urandom_range(0, pool.size() - 1)];
			r = $urandom_range(0, 99);
			if (r < 38)
				send(OP_PRESS, k);
			else if (r < 76)
				send(OP_RELEASE, k);
			else if (r < 88)
				send(OP_OTHER, $urandom_range(0, 1) ? k : 8'($urandom_range(0, 255)));
			else
				send(OP_TICK, 8'($urandom_range(0, 255)));
		end
		if (!last_phase)
			release_pool();
	endtask

	initial begin
		sb         = new();
		arst_n     = 1'b0;
		start      = 1'b0;
		item       = '0;
		term_we    = 1'b0;
		term_wdata = '0;
		n_accepted = 0;
		cycles     = 0;
		now_ms     = '0;
		idling     = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// tap pending, then a second press inside the term gives a layer
		now_ms = 0;    send(OP_PRESS, 8'd0);
		now_ms = 50;   send(OP_RELEASE, 8'd0);
		now_ms = 100;  send(OP_PRESS, 8'd0);
		now_ms = 150;  send(OP_RELEASE, 8'd0);
		// late release
		now_ms = 200;  send(OP_PRESS, 8'd255);
		now_ms = 450;  send(OP_RELEASE, 8'd255);
		// release while a tap is pending, late second press, tick flush, stray release
		now_ms = 500;  send(OP_PRESS, 8'd0);
		now_ms = 520;  send(OP_RELEASE, 8'd0);
		now_ms = 525;  send(OP_RELEASE, 8'd0);
		now_ms = 800;  send(OP_PRESS, 8'd0);
		now_ms = 810;  send(OP_RELEASE, 8'd0);
		now_ms = 1000; send(OP_TICK, 8'd17);
		now_ms = 1010; send(OP_RELEASE, 8'd0);
		// duplicate press, other key forcing a hold
		now_ms = 1100; send(OP_PRESS, 8'h55);
		now_ms = 1110; send(OP_PRESS, 8'h55);
		now_ms = 1120; send(OP_OTHER, 8'hAA);
		now_ms = 1130; send(OP_RELEASE, 8'h55);
		// fill the table, one press too many, then other key on a slot's own position
		for (int i = 1; i <= 9; i++) begin
			now_ms = 1200 + i;
			send(OP_PRESS, 8'(i));
		end
		now_ms = 1220; send(OP_OTHER, 8'd1);
		pool.delete();
		for (int i = 1; i <= 8; i++)
			pool.push_back(8'(i));
		release_pool();

		run_phase(16'd0, 30, 1'b0);
		run_phase(16'd65535, 30, 1'b0);
		run_phase(16'd1, 30, 1'b0);
		run_phase(16'($urandom_range(2, 500)), 30, 1'b0);
		run_phase(TERM_RESET, 30, 1'b0);
		run_phase(16'($urandom_range(0, 65535)), 30, 1'b0);
		// deadlines past the 32-bit time range
		if (now_ms < 32'hFFFE_0000)
			now_ms = 32'hFFFE_0000;
		run_phase(16'd65535, 30, 1'b1);

		drain();
		if (sb.errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
